// ===== sv/tpnc_pkg.sv =====
// shared constants for the three-phase neutral current estimator
package tpnc_pkg;

  // register stages ahead of the square-root chain: sort/diff, products, sum
  localparam int unsigned PreStages = 3;

  // supported range of the phase current width
  localparam int unsigned MinCurrentWidth = 4;
  localparam int unsigned MaxCurrentWidth = 32;

endpackage

// ===== sv/three_phase_neutral_current.sv =====
// Neutral current estimator: floor(sqrt(a^2+b^2+c^2-ab-bc-ca)) from three
// phase current magnitudes.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o carry one item of three unsigned
//   CURRENT_WIDTH-bit phase magnitudes. Output channel: out_valid_o /
//   out_ready_i carry the neutral current estimate of that item.
//   An item accepted at the input raises out_valid_o when it reaches the
//   final stage and leaves once out_ready_i takes it: one stage sorts and
//   takes the phase differences, one multiplies, one sums the radicand,
//   and the square root resolves one result bit per stage.
//   Throughput is one item per cycle while out_ready_i is not held low;
//   items stay in order. When the receiver holds out_ready_i low the final
//   stage holds its item and stages behind it keep filling until no empty
//   stage remains; only then does in_ready_o drop. Nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
module three_phase_neutral_current
  import tpnc_pkg::*;
#(
  parameter int unsigned CURRENT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CURRENT_WIDTH-1:0] phase_a_current_i,
  input  logic [CURRENT_WIDTH-1:0] phase_b_current_i,
  input  logic [CURRENT_WIDTH-1:0] phase_c_current_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CURRENT_WIDTH-1:0] neutral_current_o
);

  localparam int unsigned W       = CURRENT_WIDTH;
  localparam int unsigned DW      = 2 * CURRENT_WIDTH;
  localparam int unsigned Latency = PreStages + CURRENT_WIDTH;

  // valid bit per stage, stage advance enables
  logic [Latency-1:0] valid_q;
  logic [Latency:0]   adv;

  assign adv[Latency] = out_ready_i;
  for (genvar k = 0; k < Latency; k++) begin : g_adv
    assign adv[k] = !valid_q[k] || adv[k+1];
  end
  assign in_ready_o = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < Latency; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // stage 0: sort the phases and take the two gaps
  logic [W-1:0] s_a, s_b, s_c, t_lo, t_hi, mn, md, mx;
  logic [W-1:0] p_d, q_d, p_q, q_q;

  always_comb begin
    s_a  = phase_a_current_i;
    s_b  = phase_b_current_i;
    s_c  = phase_c_current_i;
    t_lo = (s_a > s_b) ? s_b : s_a;
    t_hi = (s_a > s_b) ? s_a : s_b;
    mx   = (t_hi > s_c) ? t_hi : s_c;
    md   = (t_hi > s_c) ? s_c : t_hi;
    mn   = (t_lo > md) ? md : t_lo;
    md   = (t_lo > md) ? t_lo : md;
    p_d  = md - mn;
    q_d  = mx - md;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end

  // stage 1: the three products
  logic [DW-1:0] pp_d, pq_d, qq_d, pp_q, pq_q, qq_q;

  assign pp_d = DW'(p_q) * DW'(p_q);
  assign pq_d = DW'(p_q) * DW'(q_q);
  assign qq_d = DW'(q_q) * DW'(q_q);

  always_ff @(posedge clk_i) begin
    if (adv[1] && valid_q[0]) begin
      pp_q <= pp_d;
      pq_q <= pq_d;
      qq_q <= qq_d;
    end
  end

  // stage 2: radicand p^2 + pq + q^2, never above (max - min)^2
  logic [DW-1:0] rad_d, rad_q;

  assign rad_d = pp_q + pq_q + qq_q;

  always_ff @(posedge clk_i) begin
    if (adv[2] && valid_q[1]) begin
      rad_q <= rad_d;
    end
  end

  // square root chain, one result bit per stage, most significant first
  logic [DW-1:0] rem_q  [W];
  logic [DW-1:0] root_q [W];

  for (genvar s = 0; s < W; s++) begin : g_sqrt
    localparam int unsigned Pos = 2 * (W - 1 - s);
    localparam logic [DW-1:0] Bit = DW'(1) << Pos;

    logic [DW-1:0] rem_in, root_in, rem_d, root_d;
    logic [DW:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in  = rad_q;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    always_comb begin
      trial = {1'b0, root_in} + {1'b0, Bit};
      if ({1'b0, rem_in} >= trial) begin
        rem_d  = rem_in - trial[DW-1:0];
        root_d = (root_in >> 1) + Bit;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[PreStages+s] && valid_q[PreStages+s-1]) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
      end
    end
  end

  assign out_valid_o       = valid_q[Latency-1];
  assign neutral_current_o = root_q[W-1][W-1:0];

  // the two gaps add up to max - min, so they never overflow the width
  a_gap_sum_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] |-> ({1'b0, p_q} + {1'b0, q_q}) <= {1'b0, {W{1'b1}}})
    else $error("phase gaps exceed current width");

  // floor property of the final root: remainder never above twice the root
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, rem_q[W-1]} <= ({1'b0, root_q[W-1]} << 1)))
    else $error("square root remainder too large");

  // input side stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // an accepted item always lands in the first stage
  a_first_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted item not captured");

  // width stays within the supported range
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (W >= MinCurrentWidth && W <= MaxCurrentWidth))
    else $error("unsupported current width");

endmodule
